### rtl/core/hsps_pkg.sv
// Package for the Hermite spline point store.
// Holds the transfer structs, operation and status codes and divider constants.
// No dependencies.
package hsps_pkg;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_EVAL  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SEG  = 2'd2;
  localparam logic [1:0] ST_ZERO = 2'd3;

  // restoring divider step counts: curve parameter (Q1.20) and tangent ratio
  localparam logic [5:0] SDIV_STEPS = 6'd21;
  localparam logic [5:0] RDIV_STEPS = 6'd36;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [31:0]        point_stamp;
    logic [4:0]         segment_number;
    logic [31:0]        segment_offset;
  } hsps_in_t;

  typedef struct packed {
    logic signed [31:0] curve_x;
    logic signed [31:0] curve_y;
    logic [1:0]         status;
  } hsps_out_t;

  typedef struct packed {
    logic        go;
    logic [31:0] divisor;
    logic [31:0] rem;
    logic [35:0] low;
    logic [5:0]  steps;
  } hsps_div_req_t;

endpackage

### rtl/core/hermite_spline_point_store.sv
// Hermite spline point store: timed 2D control points, non-uniform Catmull-Rom evaluation.
// Depends on hsps_pkg and hsps_div.
//
//   channel   ports                  transfer
//   command   start, busy, cmd       start & !busy
//   result    done, result           done (one cycle, no back-pressure)
//
// Add, clear and no-op: result the cycle after the transfer, busy stays low.
// Evaluate: the curve parameter is divided once, then x and then y each take their
// tangent ratios and Horner steps, through the one-bit-per-cycle divider (21 steps for
// the curve parameter, 36 per tangent ratio) and the one shared 40x33 multiplier.
// Synchronous reset empties the store; entries are not cleared.
module hermite_spline_point_store import hsps_pkg::*; #(
  parameter int MAX_POINTS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  hsps_in_t  cmd,
  output logic      busy,
  output logic      done,
  output hsps_out_t result
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int EW = CW + 6;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_DIVW  = 4'd3;
  localparam logic [3:0] S_COORD = 4'd4;
  localparam logic [3:0] S_RMUL  = 4'd5;
  localparam logic [3:0] S_RDIV  = 4'd6;
  localparam logic [3:0] S_HMUL  = 4'd7;
  localparam logic [3:0] S_HADD  = 4'd8;

  logic [3:0]    state;
  logic [CW-1:0] count;

  logic [31:0] mem_x [MAX_POINTS];
  logic [31:0] mem_y [MAX_POINTS];
  logic [31:0] mem_t [MAX_POINTS];
  logic [31:0] rd_x, rd_y, rd_t;
  logic [AW-1:0] raddr, kb;
  logic          wr_en;

  logic [31:0] xx [4];
  logic [31:0] yy [4];
  logic [31:0] tt [4];
  logic [2:0]  rd_cnt;
  logic [1:0]  rd_idx;

  logic has_prev, has_next, side, coord, kind;
  logic [1:0]  hs;
  logic [31:0] u_r, dt, dtp, dtn;
  logic [20:0] s;
  logic signed [36:0] w0, w1;
  logic signed [39:0] acc;
  logic signed [72:0] prod;
  logic [31:0] cx;

  hsps_div_req_t div_req;
  logic          div_done;
  logic [35:0]   div_quot;

  logic [EW-1:0] k_ext, cnt_ext;
  logic          full, seg_bad, next_ok;

  logic [31:0] dt_c, dtp_c, dtn_c, uc;
  logic [31:0] psel [4];
  logic signed [32:0] pm, p0, p1, p2, d, e, f, rdiff, rabs;
  logic        rneg, rsat;
  logic [31:0] mag, rdiv;
  logic [35:0] rmag;
  logic signed [36:0] rval;
  logic signed [37:0] wsum, wadj;
  logic signed [36:0] wnew;
  logic signed [39:0] d40, w040, w140, bcoef, ccoef, mul_a, tr;
  logic signed [32:0] mul_b;
  logic signed [72:0] mul_p, padj;
  logic signed [40:0] fin;
  logic [31:0] fin_sat;

  hsps_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  assign busy    = (state != S_IDLE);
  assign k_ext   = EW'(cmd.segment_number);
  assign cnt_ext = EW'(count);
  assign full    = cnt_ext >= EW'(MAX_POINTS);
  assign seg_bad = (k_ext + EW'(1) >= cnt_ext) || (k_ext + EW'(1) >= EW'(MAX_POINTS));
  assign next_ok = (k_ext + EW'(2) < cnt_ext);
  assign wr_en   = (state == S_IDLE) && start && (cmd.operation == OP_ADD) && !full;
  assign raddr   = kb + AW'(rd_cnt) - AW'(1);
  assign rd_idx  = 2'(rd_cnt - 3'd1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[count[AW-1:0]] <= cmd.point_x;
      mem_y[count[AW-1:0]] <= cmd.point_y;
      mem_t[count[AW-1:0]] <= cmd.point_stamp;
    end
    rd_x <= mem_x[raddr];
    rd_y <= mem_y[raddr];
    rd_t <= mem_t[raddr];
  end

  always_comb begin
    dt_c  = tt[2] - tt[1];
    dtp_c = has_prev ? (tt[1] - tt[0]) : 32'd1;
    dtn_c = has_next ? (tt[3] - tt[2]) : 32'd1;
    uc    = (u_r > dt_c) ? dt_c : u_r;

    for (int i = 0; i < 4; i++) begin
      psel[i] = coord ? yy[i] : xx[i];
    end
    pm = $signed({psel[0][31], psel[0]});
    p0 = $signed({psel[1][31], psel[1]});
    p1 = $signed({psel[2][31], psel[2]});
    p2 = $signed({psel[3][31], psel[3]});
    d  = p1 - p0;
    e  = p0 - pm;
    f  = p2 - p1;

    rdiff = side ? f : e;
    rneg  = rdiff[32];
    rabs  = rneg ? -rdiff : rdiff;
    mag   = rabs[31:0];
    rdiv  = side ? dtn : dtp;
    rsat  = {4'd0, prod[63:36]} >= rdiv;
    rmag  = (state == S_RDIV) ? {36{1'b1}} : div_quot;
    rval  = rneg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    wsum  = $signed({{5{d[32]}}, d}) + $signed({rval[36], rval});
    wadj  = wsum + $signed({37'd0, wsum[37]});
    wnew  = wadj[37:1];

    d40   = $signed({{7{d[32]}}, d});
    w040  = $signed({{3{w0[36]}}, w0});
    w140  = $signed({{3{w1[36]}}, w1});
    bcoef = d40 + d40 + d40 - w140 - w040 - w040;
    ccoef = w040 + w140 - d40 - d40;

    if (state == S_RMUL) begin
      mul_a = $signed({8'd0, mag});
      mul_b = $signed({1'b0, dt});
    end else begin
      mul_a = (hs == 2'd0) ? ccoef : acc;
      mul_b = $signed({12'd0, s});
    end
    mul_p = mul_a * mul_b;

    // divide by 2^20 toward zero
    padj = prod + $signed({53'd0, {20{prod[72]}}});
    tr   = padj[59:20];
    fin  = $signed({{8{p0[32]}}, p0}) + $signed({tr[39], tr});
    if ((&fin[40:31]) || !(|fin[40:31])) begin
      fin_sat = fin[31:0];
    end else begin
      fin_sat = fin[40] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      done       <= 1'b0;
      div_req.go <= 1'b0;
    end else begin
      done       <= 1'b0;
      div_req.go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            result <= '{curve_x: '0, curve_y: '0, status: ST_OK};
            unique case (cmd.operation)
              OP_ADD: begin
                done <= 1'b1;
                if (full) begin
                  result.status <= ST_FULL;
                end else begin
                  count <= count + CW'(1);
                end
              end
              OP_EVAL: begin
                if (seg_bad) begin
                  done          <= 1'b1;
                  result.status <= ST_SEG;
                end else begin
                  kb       <= AW'(cmd.segment_number);
                  has_prev <= (cmd.segment_number != 5'd0);
                  has_next <= next_ok;
                  u_r      <= cmd.segment_offset;
                  rd_cnt   <= 3'd0;
                  state    <= S_READ;
                end
              end
              OP_CLEAR: begin
                done  <= 1'b1;
                count <= '0;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          if (rd_cnt != 3'd0) begin
            xx[rd_idx] <= rd_x;
            yy[rd_idx] <= rd_y;
            tt[rd_idx] <= rd_t;
          end
          if (rd_cnt == 3'd4) begin
            state <= S_CHECK;
          end else begin
            rd_cnt <= rd_cnt + 3'd1;
          end
        end
        S_CHECK: begin
          if (dt_c == 32'd0 || dtp_c == 32'd0 || dtn_c == 32'd0) begin
            done          <= 1'b1;
            result.status <= ST_ZERO;
            state         <= S_IDLE;
          end else begin
            dt      <= dt_c;
            dtp     <= dtp_c;
            dtn     <= dtn_c;
            kind    <= 1'b0;
            div_req <= '{go: 1'b1, divisor: dt_c, rem: {1'b0, uc[31:1]},
                         low: {uc[0], 35'd0}, steps: SDIV_STEPS};
            state   <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            if (!kind) begin
              s     <= div_quot[20:0];
              coord <= 1'b0;
              state <= S_COORD;
            end else if (!side) begin
              w0 <= wnew;
              hs <= 2'd0;
              if (has_next) begin
                side  <= 1'b1;
                state <= S_RMUL;
              end else begin
                state <= S_HMUL;
              end
            end else begin
              w1    <= wnew;
              hs    <= 2'd0;
              state <= S_HMUL;
            end
          end
        end
        S_COORD: begin
          w0 <= '0;
          w1 <= '0;
          hs <= 2'd0;
          if (has_prev) begin
            side  <= 1'b0;
            state <= S_RMUL;
          end else if (has_next) begin
            side  <= 1'b1;
            state <= S_RMUL;
          end else begin
            state <= S_HMUL;
          end
        end
        S_RMUL: begin
          prod  <= mul_p;
          state <= S_RDIV;
        end
        S_RDIV: begin
          if (rsat) begin
            // ratio saturates at 2^36-1
            hs <= 2'd0;
            if (!side) begin
              w0 <= wnew;
              if (has_next) begin
                side  <= 1'b1;
                state <= S_RMUL;
              end else begin
                state <= S_HMUL;
              end
            end else begin
              w1    <= wnew;
              state <= S_HMUL;
            end
          end else begin
            kind    <= 1'b1;
            div_req <= '{go: 1'b1, divisor: rdiv, rem: {4'd0, prod[63:36]},
                         low: prod[35:0], steps: RDIV_STEPS};
            state   <= S_DIVW;
          end
        end
        S_HMUL: begin
          prod  <= mul_p;
          state <= S_HADD;
        end
        S_HADD: begin
          unique case (hs)
            2'd0: begin
              acc   <= bcoef + tr;
              hs    <= 2'd1;
              state <= S_HMUL;
            end
            2'd1: begin
              acc   <= w040 + tr;
              hs    <= 2'd2;
              state <= S_HMUL;
            end
            default: begin
              if (!coord) begin
                cx    <= fin_sat;
                coord <= 1'b1;
                state <= S_COORD;
              end else begin
                done   <= 1'b1;
                result <= '{curve_x: cx, curve_y: fin_sat, status: ST_OK};
                state  <= S_IDLE;
              end
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/hsps_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on hsps_pkg (hsps_div_req_t).
module hsps_div import hsps_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  hsps_div_req_t req,
  output logic          done,
  output logic [35:0]   quot
);

  logic        active;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [35:0] low;
  logic [31:0] dv;
  logic [32:0] r2;
  logic [32:0] diff;
  logic        ge;

  assign r2   = {rem, low[35]};
  assign diff = r2 - {1'b0, dv};
  assign ge   = r2 >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        active <= 1'b1;
        cnt    <= req.steps;
        rem    <= req.rem;
        low    <= req.low;
        dv     <= req.divisor;
        quot   <= '0;
      end else if (active) begin
        rem  <= ge ? diff[31:0] : r2[31:0];
        low  <= {low[34:0], 1'b0};
        quot <= {quot[34:0], ge};
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

### dv/hermite_spline_point_store_tb.sv
// Testbench for hermite_spline_point_store: directed and random add, evaluate, clear
// and no-op commands, each checked against a cycle-free curve predictor.
// Depends on hsps_pkg and the RTL of the block.
module hermite_spline_point_store_tb;
  import hsps_pkg::*;

  localparam int          NPTS       = 32;
  localparam logic [1:0]  OP_NONE    = 2'd3;
  localparam int          FRAC       = 20;
  localparam longint      ONE_Q20    = longint'(1) << FRAC;
  localparam longint      TAN_MAX    = (longint'(1) << 36) - 1;
  localparam int          CYCLE_CAP  = 2000000;
  localparam int          RANDOM_CMDS = 900;

  logic      clk;
  logic      rst;
  logic      start;
  hsps_in_t  cmd;
  logic      busy;
  logic      done;
  hsps_out_t result;

  hermite_spline_point_store DUT (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .result(result)
  );

  // predictor state
  logic signed [31:0] pt_x [NPTS];
  logic signed [31:0] pt_y [NPTS];
  logic [31:0]        pt_stamp [NPTS];
  int                 pt_count;

  hsps_out_t expected_results [$];
  int cycles, mismatches, cmds_sent, evals_ok, evals_err, full_hits;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = ~clk;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic longint tangent_term(longint num, longint unsigned mul,
                                          longint unsigned div);
    longint unsigned mag;
    mag = (num < 0) ? longint'(-num) : num;
    mag = (mag * mul) / div;
    if (mag > longint'(TAN_MAX)) mag = TAN_MAX;
    return (num < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic signed [31:0] curve_coord(bit on_y, int k, bit has_prev,
      bit has_next, longint unsigned dt, longint unsigned dt_prev,
      longint unsigned dt_next, longint s);
    longint p0, p1, pm, pn, d, w0, w1, b, c, t;
    p0 = on_y ? longint'(pt_y[k]) : longint'(pt_x[k]);
    p1 = on_y ? longint'(pt_y[k+1]) : longint'(pt_x[k+1]);
    pm = 0;
    pn = 0;
    if (has_prev) pm = on_y ? longint'(pt_y[k-1]) : longint'(pt_x[k-1]);
    if (has_next) pn = on_y ? longint'(pt_y[k+2]) : longint'(pt_x[k+2]);
    d = p1 - p0;
    w0 = has_prev ? (d + tangent_term(p0 - pm, dt, dt_prev)) / 2 : 0;
    w1 = has_next ? (d + tangent_term(pn - p1, dt, dt_next)) / 2 : 0;
    b = 3 * d - w1 - 2 * w0;
    c = w0 + w1 - 2 * d;
    t = (c * s) / ONE_Q20;
    t = ((b + t) * s) / ONE_Q20;
    t = ((w0 + t) * s) / ONE_Q20;
    t = p0 + t;
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return t[31:0];
  endfunction

  function automatic logic [31:0] interval_of(int k);
    return pt_stamp[k+1] - pt_stamp[k];
  endfunction

  // updates the point store and returns the expected result of one command
  function automatic hsps_out_t predict_point_store(hsps_in_t c);
    hsps_out_t r;
    int k;
    bit has_prev, has_next;
    logic [31:0] dt, dtp, dtn, u;
    longint s;
    r = '0;
    r.status = ST_OK;
    case (c.operation)
      OP_ADD: begin
        if (pt_count >= NPTS) begin
          r.status = ST_FULL;
          full_hits++;
        end else begin
          pt_x[pt_count] = c.point_x;
          pt_y[pt_count] = c.point_y;
          pt_stamp[pt_count] = c.point_stamp;
          pt_count++;
        end
      end
      OP_EVAL: begin
        k = c.segment_number;
        if (k + 1 >= pt_count) begin
          r.status = ST_SEG;
          evals_err++;
        end else begin
          has_prev = (k > 0);
          has_next = (k + 2 < pt_count);
          dt = interval_of(k);
          dtp = has_prev ? interval_of(k - 1) : 32'd1;
          dtn = has_next ? interval_of(k + 1) : 32'd1;
          if (dt == 0 || dtp == 0 || dtn == 0) begin
            r.status = ST_ZERO;
            evals_err++;
          end else begin
            u = (c.segment_offset > dt) ? dt : c.segment_offset;
            s = longint'((longint'(u) << FRAC) / longint'(dt));
            r.curve_x = curve_coord(1'b0, k, has_prev, has_next, dt, dtp, dtn, s);
            r.curve_y = curve_coord(1'b1, k, has_prev, has_next, dt, dtp, dtn, s);
            evals_ok++;
          end
        end
      end
      OP_CLEAR: pt_count = 0;
      default: ;
    endcase
    return r;
  endfunction

  // called at a falling edge; returns at a falling edge after the transfer
  task automatic send_cmd(hsps_in_t c);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_point_store(c));
    cmds_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_add(logic signed [31:0] x, logic signed [31:0] y, logic [31:0] ts);
    hsps_in_t c;
    c = '0;
    c.operation = OP_ADD;
    c.point_x = x;
    c.point_y = y;
    c.point_stamp = ts;
    c.segment_number = 5'($urandom);
    c.segment_offset = $urandom;
    send_cmd(c);
  endtask

  task automatic send_eval(logic [4:0] seg, logic [31:0] offs);
    hsps_in_t c;
    c.operation = OP_EVAL;
    c.point_x = $urandom;
    c.point_y = $urandom;
    c.point_stamp = $urandom;
    c.segment_number = seg;
    c.segment_offset = offs;
    send_cmd(c);
  endtask

  task automatic send_plain(logic [1:0] op);
    hsps_in_t c;
    c.operation = op;
    c.point_x = $urandom;
    c.point_y = $urandom;
    c.point_stamp = $urandom;
    c.segment_number = 5'($urandom);
    c.segment_offset = $urandom;
    send_cmd(c);
  endtask

  always @(posedge clk) begin
    hsps_out_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result x=%h y=%h status=%0d", result.curve_x,
                   result.curve_y, result.status);
      end else begin
        want = expected_results.pop_front();
        if (result.curve_x !== want.curve_x || result.curve_y !== want.curve_y ||
            result.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%h y=%h status=%0d, got x=%h y=%h status=%0d",
                     want.curve_x, want.curve_y, want.status,
                     result.curve_x, result.curve_y, result.status);
        end
      end
    end
  end

  // extreme coordinates, saturation, end and inner tangents, offsets past the end
  task automatic test_directed_curve();
    send_plain(OP_CLEAR);
    send_eval(5'd0, 32'd0);
    send_add(32'sh7fffffff, -32'sh80000000, 32'd0);
    send_add(-32'sh80000000, 32'sh7fffffff, 32'd1);
    send_add(32'sh7fffffff, -32'sh80000000, 32'd1000);
    send_add(32'sh00010000, 32'sh00000000, 32'hffffffff);
    send_eval(5'd0, 32'd0);
    send_eval(5'd0, 32'd1);
    send_eval(5'd1, 32'd333);
    send_eval(5'd1, 32'd999);
    send_eval(5'd1, 32'hffffffff);
    send_eval(5'd2, 32'h80000000);
    send_eval(5'd3, 32'd0);
    send_eval(5'd31, 32'd0);
    send_plain(OP_NONE);
  endtask

  // zero intervals, both in the segment and in a neighbour, and wrapping stamps
  task automatic test_directed_intervals();
    send_plain(OP_CLEAR);
    send_add(32'sd100, 32'sd200, 32'd50);
    send_add(32'sd300, -32'sd400, 32'd50);
    send_add(32'sd500, 32'sd600, 32'd10);
    send_add(-32'sd700, 32'sd800, 32'd90);
    send_eval(5'd0, 32'd0);
    send_eval(5'd1, 32'd5);
    send_eval(5'd2, 32'd40);
    send_plain(OP_CLEAR);
    send_eval(5'd0, 32'd0);
  endtask

  // random fill/evaluate phases, occasionally overfilling the store
  task automatic test_random_phases();
    int npts, nev, seg;
    logic [31:0] ts, dt, offs;
    logic signed [31:0] x, y;
    while (cmds_sent < RANDOM_CMDS + 30) begin
      if ($urandom_range(0, 9) != 0) send_plain(OP_CLEAR);
      npts = ($urandom_range(0, 5) == 0) ? NPTS + $urandom_range(1, 2) :
             $urandom_range(2, 8);
      ts = $urandom;
      for (int i = 0; i < npts; i++) begin
        case ($urandom_range(0, 15))
          0: dt = 0;
          1: dt = $urandom;
          default: dt = $urandom_range(1, 3000);
        endcase
        ts = ts + dt;
        x = ($urandom_range(0, 7) == 0) ? $urandom : $signed($urandom_range(0, 32'h1ffffff))
            - 32'sh1000000;
        y = ($urandom_range(0, 7) == 0) ? $urandom : $signed($urandom_range(0, 32'h1ffffff))
            - 32'sh1000000;
        send_add(x, y, ts);
      end
      nev = $urandom_range(3, 12);
      for (int i = 0; i < nev; i++) begin
        if ($urandom_range(0, 19) == 0) send_plain(OP_NONE);
        if (pt_count >= 2 && $urandom_range(0, 7) != 0) begin
          seg = $urandom_range(0, pt_count - 2);
          dt = interval_of(seg);
          offs = ($urandom_range(0, 7) == 0) ? $urandom :
                 ($urandom_range(0, 9) == 0) ? dt : $urandom_range(0, dt);
        end else begin
          seg = $urandom_range(0, 31);
          offs = $urandom;
        end
        send_eval(seg[4:0], offs);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cycles = 0;
    mismatches = 0;
    cmds_sent = 0;
    evals_ok = 0;
    evals_err = 0;
    full_hits = 0;
    burst_left = 0;
    pt_count = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_curve();
    test_directed_intervals();
    test_random_phases();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("%0d commands sent: %0d evaluates checked, %0d rejected evaluates,",
             cmds_sent, evals_ok, evals_err);
    $display("%0d adds to a full store, %0d mismatches", full_hits, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
